[rtl/grid_astar_path_planner_macros.svh]
// ------------------------------------------------------------------------
// grid planner assertion macros
// shared concurrent assertion forms, clocked on clk, idle in reset
// ------------------------------------------------------------------------
`ifndef GRID_ASTAR_PATH_PLANNER_MACROS_SVH
`define GRID_ASTAR_PATH_PLANNER_MACROS_SVH

// same-cycle implication
`define GAP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gap_pkg.sv]
// ------------------------------------------------------------------------
// gap_pkg
// types and fixed constants of the grid path planner
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package gap_pkg;

    typedef enum logic [3:0] {
        S_CLR_MAP,
        S_IDLE,
        S_CLR_NODE,
        S_SEED,
        S_SCAN,
        S_SCAN_END,
        S_CLOSE,
        S_NB_RD,
        S_NB_CHK,
        S_TR_RD,
        S_TR_WR,
        S_EM_RD,
        S_EM_LD,
        S_EM_WAIT
    } state_t;

    typedef logic [1:0] status_t;
    typedef logic [1:0] dir_t;

    localparam status_t ST_UNSEEN = 2'd0;
    localparam status_t ST_OPEN   = 2'd1;
    localparam status_t ST_CLOSED = 2'd2;

    localparam dir_t DIR_UP    = 2'd0;
    localparam dir_t DIR_RIGHT = 2'd1;
    localparam dir_t DIR_DOWN  = 2'd2;
    localparam dir_t DIR_LEFT  = 2'd3;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_PLAN  = 1'b1;

    localparam logic REG_ROWS    = 1'b0;
    localparam logic REG_COLUMNS = 1'b1;

    localparam int FLD_W      = 3;
    localparam int CRD_W      = 7;
    localparam int PATH_DEPTH = 64;
    localparam int PATH_AW    = 6;

endpackage

[rtl/gap_node_store.sv]
// ------------------------------------------------------------------------
// gap_node_store
// occupancy map and per-cell search record, one read port, registered
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module gap_node_store #(
    parameter int CELLS = 64,
    parameter int IW    = 6,
    parameter int GW    = 6,
    parameter int OW    = 7
) (
    input  logic              clk,
    input  logic [IW-1:0]     waddr,
    input  logic              map_we,
    input  logic              map_wdata,
    input  logic              node_we,
    input  gap_pkg::status_t  node_wstatus,
    input  logic [GW-1:0]     node_wcost,
    input  gap_pkg::dir_t     node_wdir,
    input  logic [OW-1:0]     node_word,
    input  logic [IW-1:0]     raddr,
    output logic              rd_free,
    output gap_pkg::status_t  rd_status,
    output logic [GW-1:0]     rd_cost,
    output gap_pkg::dir_t     rd_dir,
    output logic [OW-1:0]     rd_order
);
    import gap_pkg::*;

    logic              map_mem    [CELLS];
    status_t           status_mem [CELLS];
    logic [GW-1:0]     cost_mem   [CELLS];
    dir_t              dir_mem    [CELLS];
    logic [OW-1:0]     order_mem  [CELLS];

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[waddr] <= map_wdata;
        end
        if (node_we)
        begin
            status_mem[waddr] <= node_wstatus;
            cost_mem[waddr]   <= node_wcost;
            dir_mem[waddr]    <= node_wdir;
            order_mem[waddr]  <= node_word;
        end
        rd_free   <= map_mem[raddr];
        rd_status <= status_mem[raddr];
        rd_cost   <= cost_mem[raddr];
        rd_dir    <= dir_mem[raddr];
        rd_order  <= order_mem[raddr];
    end

endmodule

[rtl/gap_cost_unit.sv]
// ------------------------------------------------------------------------
// gap_cost_unit
// shared f = g + manhattan distance and best-candidate compare
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module gap_cost_unit #(
    parameter int GW = 6,
    parameter int OW = 7,
    parameter int FW = 8,
    parameter int RW = 3,
    parameter int CW = 3
) (
    input  logic [GW-1:0]              cost,
    input  logic [OW-1:0]              order,
    input  logic [RW-1:0]              row,
    input  logic [CW-1:0]              col,
    input  logic [gap_pkg::FLD_W-1:0]  goal_row,
    input  logic [gap_pkg::FLD_W-1:0]  goal_col,
    input  logic                       any,
    input  logic [FW-1:0]              best_f,
    input  logic [OW-1:0]              best_order,
    output logic [FW-1:0]              f,
    output logic                       take
);
    import gap_pkg::*;

    logic [CRD_W-1:0] gr, gc, r, c, dr, dc;

    always_comb
    begin
        gr = CRD_W'(goal_row);
        gc = CRD_W'(goal_col);
        r  = CRD_W'(row);
        c  = CRD_W'(col);
        dr = (gr > r) ? (gr - r) : (r - gr);
        dc = (gc > c) ? (gc - c) : (c - gc);
        f  = FW'(cost) + FW'(dr) + FW'(dc);
        take = !any || (f < best_f) || ((f == best_f) && (order < best_order));
    end

endmodule

[rtl/gap_path_buf.sv]
// ------------------------------------------------------------------------
// gap_path_buf
// path cells written goal first during trace, read start first
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module gap_path_buf (
    input  logic                         clk,
    input  logic                         we,
    input  logic [gap_pkg::PATH_AW-1:0]  waddr,
    input  logic [gap_pkg::FLD_W-1:0]    wrow,
    input  logic [gap_pkg::FLD_W-1:0]    wcol,
    input  logic [gap_pkg::PATH_AW-1:0]  raddr,
    output logic [gap_pkg::FLD_W-1:0]    rrow,
    output logic [gap_pkg::FLD_W-1:0]    rcol
);
    import gap_pkg::*;

    logic [FLD_W-1:0] row_mem [PATH_DEPTH];
    logic [FLD_W-1:0] col_mem [PATH_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            row_mem[waddr] <= wrow;
            col_mem[waddr] <= wcol;
        end
        rrow <= row_mem[raddr];
        rcol <= col_mem[raddr];
    end

endmodule

[rtl/grid_astar_path_planner.sv]
// sequence: a map write is taken in idle; a plan clears the search record and seeds the start,
//   then each expansion scans every cell, closes the best open cell and checks its neighbors,
//   then the path is traced back from the goal and one result is emitted per path cell (CELLS = MAX_ROWS x MAX_COLUMNS)
// throughput: one item at a time, set by the single scan/compare unit and its memory port
// reset: after rst_n releases, a clearing pass over all CELLS cells blocks the map as occupied
//   before the first item is taken; config registers return to 8 rows by 8 columns
// ------------------------------------------------------------------------
// grid_astar_path_planner
// a* search on a 4-connected occupancy grid with a manhattan heuristic
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_astar_path_planner_macros.svh"

module grid_astar_path_planner #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration writes
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [3:0]                   cfg_wdata,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         kind,
    input  logic [gap_pkg::FLD_W-1:0]    cell_row,
    input  logic [gap_pkg::FLD_W-1:0]    cell_column,
    input  logic                         cell_free,
    input  logic [gap_pkg::FLD_W-1:0]    goal_row,
    input  logic [gap_pkg::FLD_W-1:0]    goal_column,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [gap_pkg::FLD_W-1:0]    path_row,
    output logic [gap_pkg::FLD_W-1:0]    path_column,
    output logic                         reached,
    output logic                         last
);
    import gap_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
    localparam int IW    = $clog2(CELLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int GW    = IW;
    localparam int OW    = $clog2(CELLS + 1);
    localparam int FW    = $clog2(CELLS + MAX_ROWS + MAX_COLUMNS + 16);

    // linear cell address, row major
    function automatic logic [IW-1:0] idx_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
        idx_of = IW'(r) * IW'(MAX_COLUMNS) + IW'(c);
    endfunction

    // sequencer state
    state_t             state_reg, state_next;
    logic [IW-1:0]      sweep_reg, sweep_next;

    // configuration and per-plan constants
    logic [3:0]         rows_reg, cols_reg;
    logic [CRD_W-1:0]   nr_reg, nr_next, nc_reg, nc_next;
    logic [FLD_W-1:0]   goal_r_reg, goal_r_next, goal_c_reg, goal_c_next;

    // scan walk and read pipeline tag
    logic [RW-1:0]      scan_r_reg, scan_r_next, pr_reg, pr_next;
    logic [CW-1:0]      scan_c_reg, scan_c_next, pc_reg, pc_next;
    logic               pv_reg, pv_next;

    // best open cell so far
    logic               any_reg, any_next;
    logic [RW-1:0]      best_r_reg, best_r_next;
    logic [CW-1:0]      best_c_reg, best_c_next;
    logic [FW-1:0]      best_f_reg, best_f_next;
    logic [OW-1:0]      best_ord_reg, best_ord_next;
    logic [GW-1:0]      best_cost_reg, best_cost_next;
    dir_t               best_dir_reg, best_dir_next;

    logic [OW-1:0]      ins_cnt_reg, ins_cnt_next;
    dir_t               nb_dir_reg, nb_dir_next;

    // trace and emit
    logic [RW-1:0]      cur_r_reg, cur_r_next;
    logic [CW-1:0]      cur_c_reg, cur_c_next;
    logic [PATH_AW-1:0] k_reg, k_next, len_last_reg, len_last_next, em_k_reg, em_k_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [FLD_W-1:0]   out_row_reg, out_row_next, out_col_reg, out_col_next;
    logic               out_reached_reg, out_reached_next, out_last_reg, out_last_next;

    // store ports
    logic [IW-1:0]      waddr, raddr;
    logic               map_we, map_wdata, node_we;
    status_t            node_wstatus;
    logic [GW-1:0]      node_wcost;
    dir_t               node_wdir;
    logic [OW-1:0]      node_word;
    logic               rd_free;
    status_t            rd_status;
    logic [GW-1:0]      rd_cost;
    dir_t               rd_dir;
    logic [OW-1:0]      rd_order;

    logic               path_we;
    logic [FLD_W-1:0]   path_rrow, path_rcol;

    logic [FW-1:0]      cu_f;
    logic               cu_take;

    // decoded conditions
    logic               in_xfer, out_xfer, scan_last, sweep_last, start_bad, write_ok;
    logic               at_goal, too_long, nb_ok, nb_new, dir_last;
    logic [RW-1:0]      nb_r;
    logic [CW-1:0]      nb_c;
    logic [CRD_W-1:0]   nr_clamp, nc_clamp;

    gap_node_store #(.CELLS(CELLS), .IW(IW), .GW(GW), .OW(OW)) u_store (
        .clk          (clk),
        .waddr        (waddr),
        .map_we       (map_we),
        .map_wdata    (map_wdata),
        .node_we      (node_we),
        .node_wstatus (node_wstatus),
        .node_wcost   (node_wcost),
        .node_wdir    (node_wdir),
        .node_word    (node_word),
        .raddr        (raddr),
        .rd_free      (rd_free),
        .rd_status    (rd_status),
        .rd_cost      (rd_cost),
        .rd_dir       (rd_dir),
        .rd_order     (rd_order)
    );

    gap_cost_unit #(.GW(GW), .OW(OW), .FW(FW), .RW(RW), .CW(CW)) u_cost (
        .cost       (rd_cost),
        .order      (rd_order),
        .row        (pr_reg),
        .col        (pc_reg),
        .goal_row   (goal_r_reg),
        .goal_col   (goal_c_reg),
        .any        (any_reg),
        .best_f     (best_f_reg),
        .best_order (best_ord_reg),
        .f          (cu_f),
        .take       (cu_take)
    );

    gap_path_buf u_path (
        .clk   (clk),
        .we    (path_we),
        .waddr (k_reg),
        .wrow  (FLD_W'(cur_r_reg)),
        .wcol  (FLD_W'(cur_c_reg)),
        .raddr (em_k_reg),
        .rrow  (path_rrow),
        .rcol  (path_rcol)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign path_row    = out_row_reg;
    assign path_column = out_col_reg;
    assign reached     = out_reached_reg;
    assign last        = out_last_reg;

    // shared decodes
    always_comb
    begin
        in_xfer    = in_valid && !in_stall;
        out_xfer   = out_valid_reg && !out_stall;
        scan_last  = (scan_r_reg == RW'(MAX_ROWS - 1)) && (scan_c_reg == CW'(MAX_COLUMNS - 1));
        sweep_last = (sweep_reg == IW'(CELLS - 1));
        // register values clamped into the grid
        if (rows_reg == 4'd0)
            nr_clamp = CRD_W'(1);
        else if (CRD_W'(rows_reg) > CRD_W'(MAX_ROWS))
            nr_clamp = CRD_W'(MAX_ROWS);
        else
            nr_clamp = CRD_W'(rows_reg);
        if (cols_reg == 4'd0)
            nc_clamp = CRD_W'(1);
        else if (CRD_W'(cols_reg) > CRD_W'(MAX_COLUMNS))
            nc_clamp = CRD_W'(MAX_COLUMNS);
        else
            nc_clamp = CRD_W'(cols_reg);
        start_bad = (CRD_W'(cell_row) >= nr_clamp) || (CRD_W'(cell_column) >= nc_clamp);
        write_ok  = (CRD_W'(cell_row) < CRD_W'(MAX_ROWS))
                 && (CRD_W'(cell_column) < CRD_W'(MAX_COLUMNS));
        at_goal   = (CRD_W'(best_r_reg) == CRD_W'(goal_r_reg))
                 && (CRD_W'(best_c_reg) == CRD_W'(goal_c_reg));
        // a path longer than the result buffer is reported as unreachable
        too_long  = (13'(best_cost_reg) + 13'd1) > 13'(PATH_DEPTH);
        dir_last  = (nb_dir_reg == DIR_LEFT);
        nb_r = best_r_reg;
        nb_c = best_c_reg;
        nb_ok = 1'b0;
        unique case (nb_dir_reg)
            DIR_UP:
            begin
                nb_r  = best_r_reg - RW'(1);
                nb_ok = (best_r_reg != '0);
            end
            DIR_RIGHT:
            begin
                nb_c  = best_c_reg + CW'(1);
                nb_ok = (CRD_W'(best_c_reg) + CRD_W'(1)) < nc_reg;
            end
            DIR_DOWN:
            begin
                nb_r  = best_r_reg + RW'(1);
                nb_ok = (CRD_W'(best_r_reg) + CRD_W'(1)) < nr_reg;
            end
            default:
            begin
                nb_c  = best_c_reg - CW'(1);
                nb_ok = (best_c_reg != '0);
            end
        endcase
        nb_new = rd_free && (rd_status == ST_UNSEEN);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR_MAP:
                if (sweep_last) state_next = S_IDLE;
            S_IDLE:
                if (in_xfer && kind == KIND_PLAN)
                    state_next = start_bad ? S_EM_WAIT : S_CLR_NODE;
            S_CLR_NODE:
                if (sweep_last) state_next = S_SEED;
            S_SEED:
                state_next = S_SCAN;
            S_SCAN:
                if (scan_last) state_next = S_SCAN_END;
            S_SCAN_END:
                state_next = S_CLOSE;
            S_CLOSE:
                if (!any_reg || (at_goal && too_long))
                    state_next = S_EM_WAIT;
                else if (at_goal)
                    state_next = S_TR_RD;
                else
                    state_next = S_NB_RD;
            S_NB_RD:
                if (nb_ok)
                    state_next = S_NB_CHK;
                else if (dir_last)
                    state_next = S_SCAN;
            S_NB_CHK:
                state_next = dir_last ? S_SCAN : S_NB_RD;
            S_TR_RD:
                state_next = S_TR_WR;
            S_TR_WR:
                state_next = (k_reg == '0) ? S_EM_RD : S_TR_RD;
            S_EM_RD:
                state_next = S_EM_LD;
            S_EM_LD:
                state_next = S_EM_WAIT;
            S_EM_WAIT:
                if (out_xfer) state_next = out_last_reg ? S_IDLE : S_EM_RD;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and port controls
    always_comb
    begin
        sweep_next       = sweep_reg;
        nr_next          = nr_reg;
        nc_next          = nc_reg;
        goal_r_next      = goal_r_reg;
        goal_c_next      = goal_c_reg;
        scan_r_next      = scan_r_reg;
        scan_c_next      = scan_c_reg;
        pr_next          = scan_r_reg;
        pc_next          = scan_c_reg;
        pv_next          = (state_reg == S_SCAN);
        any_next         = any_reg;
        best_r_next      = best_r_reg;
        best_c_next      = best_c_reg;
        best_f_next      = best_f_reg;
        best_ord_next    = best_ord_reg;
        best_cost_next   = best_cost_reg;
        best_dir_next    = best_dir_reg;
        ins_cnt_next     = ins_cnt_reg;
        nb_dir_next      = nb_dir_reg;
        cur_r_next       = cur_r_reg;
        cur_c_next       = cur_c_reg;
        k_next           = k_reg;
        len_last_next    = len_last_reg;
        em_k_next        = em_k_reg;
        out_valid_next   = out_valid_reg;
        out_row_next     = out_row_reg;
        out_col_next     = out_col_reg;
        out_reached_next = out_reached_reg;
        out_last_next    = out_last_reg;

        waddr        = sweep_reg;
        raddr        = idx_of(scan_r_reg, scan_c_reg);
        map_we       = 1'b0;
        map_wdata    = 1'b0;
        node_we      = 1'b0;
        node_wstatus = ST_UNSEEN;
        node_wcost   = '0;
        node_wdir    = DIR_UP;
        node_word    = '0;
        path_we      = 1'b0;

        // fold each scanned open cell into the running best
        if (pv_reg && rd_status == ST_OPEN && cu_take)
        begin
            any_next       = 1'b1;
            best_r_next    = pr_reg;
            best_c_next    = pc_reg;
            best_f_next    = cu_f;
            best_ord_next  = rd_order;
            best_cost_next = rd_cost;
            best_dir_next  = rd_dir;
        end

        unique case (state_reg)
            S_CLR_MAP:
            begin
                map_we     = 1'b1;
                node_we    = 1'b1;
                sweep_next = sweep_reg + IW'(1);
            end
            S_IDLE:
            begin
                waddr     = IW'(idx_of(RW'(cell_row), CW'(cell_column)));
                map_wdata = cell_free;
                if (in_xfer && kind == KIND_WRITE)
                    map_we = write_ok;
                if (in_xfer && kind == KIND_PLAN)
                begin
                    nr_next     = nr_clamp;
                    nc_next     = nc_clamp;
                    goal_r_next = goal_row;
                    goal_c_next = goal_column;
                    best_r_next = RW'(cell_row);
                    best_c_next = CW'(cell_column);
                    sweep_next  = '0;
                    if (start_bad)
                    begin
                        out_valid_next   = 1'b1;
                        out_row_next     = '0;
                        out_col_next     = '0;
                        out_reached_next = 1'b0;
                        out_last_next    = 1'b1;
                    end
                end
            end
            S_CLR_NODE:
            begin
                node_we    = 1'b1;
                sweep_next = sweep_reg + IW'(1);
            end
            S_SEED:
            begin
                waddr        = idx_of(best_r_reg, best_c_reg);
                node_we      = 1'b1;
                node_wstatus = ST_OPEN;
                ins_cnt_next = OW'(1);
                scan_r_next  = '0;
                scan_c_next  = '0;
                any_next     = 1'b0;
            end
            S_SCAN:
            begin
                if (scan_c_reg == CW'(MAX_COLUMNS - 1))
                begin
                    scan_c_next = '0;
                    scan_r_next = scan_r_reg + RW'(1);
                end
                else
                begin
                    scan_c_next = scan_c_reg + CW'(1);
                end
            end
            S_SCAN_END:
            begin
            end
            S_CLOSE:
            begin
                waddr        = idx_of(best_r_reg, best_c_reg);
                node_we      = any_reg;
                node_wstatus = ST_CLOSED;
                node_wcost   = best_cost_reg;
                node_wdir    = best_dir_reg;
                node_word    = best_ord_reg;
                nb_dir_next  = DIR_UP;
                cur_r_next   = best_r_reg;
                cur_c_next   = best_c_reg;
                k_next         = PATH_AW'(best_cost_reg);
                len_last_next  = PATH_AW'(best_cost_reg);
                em_k_next      = '0;
                if (!any_reg || (at_goal && too_long))
                begin
                    out_valid_next   = 1'b1;
                    out_row_next     = '0;
                    out_col_next     = '0;
                    out_reached_next = 1'b0;
                    out_last_next    = 1'b1;
                end
            end
            S_NB_RD:
            begin
                raddr = idx_of(nb_r, nb_c);
                if (!nb_ok)
                begin
                    nb_dir_next = nb_dir_reg + 2'd1;
                    scan_r_next = '0;
                    scan_c_next = '0;
                    any_next    = 1'b0;
                end
            end
            S_NB_CHK:
            begin
                waddr        = idx_of(nb_r, nb_c);
                node_wstatus = ST_OPEN;
                node_wcost   = best_cost_reg + GW'(1);
                node_wdir    = nb_dir_reg;
                node_word    = ins_cnt_reg;
                if (nb_new)
                begin
                    node_we      = 1'b1;
                    ins_cnt_next = ins_cnt_reg + OW'(1);
                end
                nb_dir_next = nb_dir_reg + 2'd1;
                scan_r_next = '0;
                scan_c_next = '0;
                any_next    = 1'b0;
            end
            S_TR_RD:
            begin
                raddr = idx_of(cur_r_reg, cur_c_reg);
            end
            S_TR_WR:
            begin
                path_we = 1'b1;
                k_next  = k_reg - PATH_AW'(1);
                // step back toward the parent cell
                unique case (rd_dir)
                    DIR_UP:    cur_r_next = cur_r_reg + RW'(1);
                    DIR_RIGHT: cur_c_next = cur_c_reg - CW'(1);
                    DIR_DOWN:  cur_r_next = cur_r_reg - RW'(1);
                    default:   cur_c_next = cur_c_reg + CW'(1);
                endcase
            end
            S_EM_RD:
            begin
            end
            S_EM_LD:
            begin
                out_valid_next   = 1'b1;
                out_row_next     = path_rrow;
                out_col_next     = path_rcol;
                out_reached_next = 1'b1;
                out_last_next    = (em_k_reg == len_last_reg);
            end
            S_EM_WAIT:
            begin
                if (out_xfer)
                begin
                    out_valid_next = 1'b0;
                    em_k_next      = em_k_reg + PATH_AW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR_MAP;
            sweep_reg     <= '0;
            rows_reg      <= 4'd8;
            cols_reg      <= 4'd8;
            pv_reg        <= 1'b0;
            any_reg       <= 1'b0;
            ins_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            pv_reg        <= pv_next;
            any_reg       <= any_next;
            ins_cnt_reg   <= ins_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == REG_ROWS)
                rows_reg <= cfg_wdata;
            if (cfg_we && cfg_index == REG_COLUMNS)
                cols_reg <= cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        nr_reg          <= nr_next;
        nc_reg          <= nc_next;
        goal_r_reg      <= goal_r_next;
        goal_c_reg      <= goal_c_next;
        scan_r_reg      <= scan_r_next;
        scan_c_reg      <= scan_c_next;
        pr_reg          <= pr_next;
        pc_reg          <= pc_next;
        best_r_reg      <= best_r_next;
        best_c_reg      <= best_c_next;
        best_f_reg      <= best_f_next;
        best_ord_reg    <= best_ord_next;
        best_cost_reg   <= best_cost_next;
        best_dir_reg    <= best_dir_next;
        nb_dir_reg      <= nb_dir_next;
        cur_r_reg       <= cur_r_next;
        cur_c_reg       <= cur_c_next;
        k_reg           <= k_next;
        len_last_reg    <= len_last_next;
        em_k_reg        <= em_k_next;
        out_row_reg     <= out_row_next;
        out_col_reg     <= out_col_next;
        out_reached_reg <= out_reached_next;
        out_last_reg    <= out_last_next;
    end

    `GAP_ASSERT_NOW(a_result_only_in_wait, out_valid_reg, state_reg == S_EM_WAIT, "result outside wait")
    `GAP_ASSERT_NEXT(a_write_no_result, in_xfer && kind == KIND_WRITE, !out_valid_reg, "write made a result")
    `GAP_ASSERT_NEXT(a_last_to_idle, out_xfer && out_last_reg, state_reg == S_IDLE, "no idle after last")
    `GAP_ASSERT_NOW(a_insert_bound, 1'b1, ins_cnt_reg <= OW'(CELLS), "insert counter overrun")

endmodule
